// ===== hdl/sql_script_statement_splitter_macros.svh =====
// assertion macros for the sql script statement splitter
// used by the top level only, no other dependencies
`ifndef SQL_SCRIPT_STATEMENT_SPLITTER_MACROS_SVH
`define SQL_SCRIPT_STATEMENT_SPLITTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sss assertion failed");

// condition must never hold
`define SSS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sss assertion failed");

`endif

// ===== hdl/sss_pkg.sv =====
// shared types and constants for the sql script statement splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_STMT_END   = 2'd1,
      KIND_DONE_OK    = 2'd2,
      KIND_DONE_QUOTE = 2'd3
   } kind_type;

   localparam logic [1:0] DIALECT_PG     = 2'd1;
   localparam logic [1:0] DIALECT_ORACLE = 2'd2;

   localparam int FIFO_AW    = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;
   localparam int FIFO_CW    = FIFO_AW + 1;

   // results of one input transaction, one or two of them
   typedef struct packed {
      logic       two;
      kind_type   kind0;
      logic [7:0] data0;
      kind_type   kind1;
      logic [7:0] data1;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } fifo_wr_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [FIFO_CW-1:0] count;
   } fifo_stat_type;

endpackage

`default_nettype wire

// ===== hdl/sss_front.sv =====
// front end: tracks quotes, dollar blocks, words and nesting per byte
// and builds the result entry of each transaction; uses sss_pkg
`timescale 1ns / 1ps
`default_nettype none

module sss_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         dialect,
   input  wire logic               accept,
   input  wire logic [7:0]         script_byte,
   input  wire logic               end_of_script,
   output sss_pkg::fifo_wr_type    fifo_wr
);
   import sss_pkg::*;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_word_char(input logic [7:0] b);
      return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
   endfunction

   function automatic logic [7:0] begin_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h42;
         3'd1:    c = 8'h45;
         3'd2:    c = 8'h47;
         3'd3:    c = 8'h49;
         3'd4:    c = 8'h4E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] end_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h45;
         3'd1:    c = 8'h4E;
         3'd2:    c = 8'h44;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic signed [7:0] level_step(input logic signed [7:0] lvl,
                                                    input logic up);
      logic signed [7:0] r;
      r = lvl;
      if (up && lvl != 8'sd127) begin
         r = lvl + 8'sd1;
      end else if (!up && lvl != -8'sd128) begin
         r = lvl - 8'sd1;
      end
      return r;
   endfunction

   logic signed [7:0] nest_ff, nest_in;
   logic              escape_ff, escape_in;
   logic              quote_ff, quote_in;
   logic              pending_ff, pending_in;
   logic              ident_ff, ident_in;
   logic [2:0]        len_ff, len_in;
   logic              mbegin_ff, mbegin_in;
   logic              mend_ff, mend_in;
   logic              started_ff, started_in;

   logic              emit_b, emit_crlf, emit_end, emit_done, consumed;
   logic [7:0]        b, up;
   entry_type         entry;
   logic              has_result;

   always_comb begin
      nest_in    = nest_ff;
      escape_in  = escape_ff;
      quote_in   = quote_ff;
      pending_in = pending_ff;
      ident_in   = ident_ff;
      len_in     = len_ff;
      mbegin_in  = mbegin_ff;
      mend_in    = mend_ff;
      started_in = started_ff;
      emit_b     = 1'b0;
      emit_crlf  = 1'b0;
      emit_end   = 1'b0;
      emit_done  = 1'b0;
      consumed   = 1'b0;
      b          = script_byte;
      up         = to_upper(script_byte);

      if (end_of_script) begin
         emit_done  = 1'b1;
         nest_in    = '0;
         escape_in  = 1'b0;
         quote_in   = 1'b0;
         pending_in = 1'b0;
         ident_in   = 1'b0;
         len_in     = '0;
         mbegin_in  = 1'b0;
         mend_in    = 1'b0;
         started_in = 1'b0;
      end else if (quote_ff) begin
         emit_b = 1'b1;
         if (b == CH_QUOTE) begin
            quote_in = 1'b0;
         end
      end else begin
         if (pending_ff) begin
            pending_in = 1'b0;
            if (b == CH_DOLLAR) begin
               emit_b    = 1'b1;
               escape_in = !escape_ff;
               consumed  = 1'b1;
            end
         end
         if (!consumed && ident_ff) begin
            if (is_word_char(b)) begin
               mbegin_in = mbegin_ff && (len_ff < 3'd5) && (up == begin_char(len_ff));
               mend_in   = mend_ff && (len_ff < 3'd3) && (up == end_char(len_ff));
               len_in    = (len_ff < 3'd6) ? len_ff + 3'd1 : len_ff;
               emit_b    = 1'b1;
               consumed  = 1'b1;
            end else begin
               // word complete
               if (!escape_ff) begin
                  if (mbegin_ff && len_ff == 3'd5) begin
                     nest_in = level_step(nest_ff, 1'b1);
                  end
                  if (mend_ff && len_ff == 3'd3) begin
                     nest_in = level_step(nest_ff, 1'b0);
                  end
               end
               ident_in  = 1'b0;
               len_in    = '0;
               mbegin_in = 1'b0;
               mend_in   = 1'b0;
            end
         end
         if (!consumed) begin
            if (is_alpha(b) || b == CH_UNDER) begin
               ident_in  = 1'b1;
               mbegin_in = (up == begin_char(3'd0));
               mend_in   = (up == end_char(3'd0));
               len_in    = 3'd1;
               emit_b    = 1'b1;
            end else if (b == CH_QUOTE) begin
               emit_b   = 1'b1;
               quote_in = 1'b1;
            end else if (dialect == DIALECT_PG && b == CH_DOLLAR) begin
               emit_b     = 1'b1;
               pending_in = 1'b1;
            end else if (b == CH_SEMI && nest_in == 8'sd0 && !escape_ff) begin
               emit_end   = 1'b1;
               started_in = 1'b0;
            end else begin
               if (!escape_ff) begin
                  if (b == CH_LPAREN) begin
                     nest_in = level_step(nest_in, 1'b1);
                  end
                  if (b == CH_RPAREN) begin
                     nest_in = level_step(nest_in, 1'b0);
                  end
               end
               if (b != CH_CR) begin
                  if (dialect == DIALECT_ORACLE && b == CH_LF) begin
                     emit_crlf = 1'b1;
                  end else begin
                     emit_b = 1'b1;
                  end
               end
            end
         end
      end

      entry       = '0;
      has_result  = 1'b0;
      if (emit_done) begin
         has_result  = 1'b1;
         entry.kind0 = quote_ff ? KIND_DONE_QUOTE : KIND_DONE_OK;
      end else if (emit_end) begin
         has_result  = 1'b1;
         entry.kind0 = KIND_STMT_END;
      end else if (emit_crlf) begin
         // leading line breaks of a statement are dropped
         if (started_ff) begin
            has_result  = 1'b1;
            entry.two   = 1'b1;
            entry.kind0 = KIND_BYTE;
            entry.data0 = CH_CR;
            entry.kind1 = KIND_BYTE;
            entry.data1 = CH_LF;
         end
      end else if (emit_b) begin
         if (started_ff || (b != CH_CR && b != CH_LF)) begin
            has_result  = 1'b1;
            started_in  = 1'b1;
            entry.kind0 = KIND_BYTE;
            entry.data0 = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nest_ff    <= '0;
         escape_ff  <= 1'b0;
         quote_ff   <= 1'b0;
         pending_ff <= 1'b0;
         ident_ff   <= 1'b0;
         len_ff     <= '0;
         mbegin_ff  <= 1'b0;
         mend_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else if (accept) begin
         nest_ff    <= nest_in;
         escape_ff  <= escape_in;
         quote_ff   <= quote_in;
         pending_ff <= pending_in;
         ident_ff   <= ident_in;
         len_ff     <= len_in;
         mbegin_ff  <= mbegin_in;
         mend_ff    <= mend_in;
         started_ff <= started_in;
      end
   end

   assign fifo_wr.push  = accept && has_result;
   assign fifo_wr.entry = entry;

endmodule

`default_nettype wire

// ===== hdl/sss_fifo.sv =====
// queue of result entries between front and back end
// uses sss_pkg
`timescale 1ns / 1ps
`default_nettype none

module sss_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sss_pkg::fifo_wr_type fifo_wr,
   input  wire logic                 pop,
   output sss_pkg::entry_type        head,
   output sss_pkg::fifo_stat_type    stat
);
   import sss_pkg::*;

   entry_type          mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      do_push   = fifo_wr.push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= fifo_wr.entry;
      end
   end

   assign head       = mem[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign stat.count = count_ff;

endmodule

`default_nettype wire

// ===== hdl/sss_back.sv =====
// back end: unpacks queued entries into single results and
// holds the result register; uses sss_pkg
`timescale 1ns / 1ps
`default_nettype none

module sss_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sss_pkg::entry_type     head,
   input  wire sss_pkg::fifo_stat_type stat,
   output logic                        fifo_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run
);
   import sss_pkg::*;

   logic       valid_ff;
   kind_type   kind_ff;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       idx_ff;
   logic       load;

   assign load     = !stat.empty && (!valid_ff || rsp_pop);
   assign fifo_pop = load && (idx_ff || !head.two);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= head.two && !idx_ff;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= idx_ff ? head.kind1 : head.kind0;
         data_ff <= idx_ff ? head.data1 : head.data0;
         last_ff <= idx_ff || !head.two;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_byte    = data_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

// ===== hdl/sql_script_statement_splitter.sv =====
// SQL script statement splitter, top level
// depends on sss_pkg, sss_front, sss_fifo, sss_back and the macros header
//
// Takes one script byte per cycle on the req_ queue port while req_full is low
// and returns statement bytes, statement-end markers and a script-done status on
// the rsp_ queue port. Each accepted transaction gives zero, one or two results,
// which pass a four-entry queue and an output register and leave one per cycle
// while the consumer pops; the input runs at one byte per clock until the queue
// fills, which only happens when the consumer stalls or the Oracle dialect turns
// newlines into CR LF pairs. The user must write the dialect register through
// csr_ only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "sql_script_statement_splitter_macros.svh"

module sql_script_statement_splitter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_script_byte,
   input  wire logic       req_end_of_script,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_dialect
);
   import sss_pkg::*;

   logic [1:0]    dialect_reg_ff;
   logic          accept;
   fifo_wr_type   fifo_wr;
   entry_type     head;
   fifo_stat_type fifo_stat;
   logic          fifo_pop;

   assign csr_ready = 1'b1;
   assign req_full  = fifo_stat.full;
   assign accept    = req_push && !fifo_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         dialect_reg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         dialect_reg_ff <= csr_dialect;
      end
   end

   sss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .dialect       (dialect_reg_ff),
      .accept        (accept),
      .script_byte   (req_script_byte),
      .end_of_script (req_end_of_script),
      .fifo_wr       (fifo_wr)
   );

   sss_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .fifo_wr (fifo_wr),
      .pop     (fifo_pop),
      .head    (head),
      .stat    (fifo_stat)
   );

   sss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .stat            (fifo_stat),
      .fifo_pop        (fifo_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // markers and status carry no byte and always close their transaction
   `SSS_ASSERT_IMPLY(a_marker_zero, clock, reset, !rsp_empty && rsp_kind != KIND_BYTE, rsp_out_byte == 8'h00)
   `SSS_ASSERT_IMPLY(a_marker_last, clock, reset, !rsp_empty && rsp_kind != KIND_BYTE, rsp_last_of_run)
   `SSS_ASSERT_NEVER(a_fifo_bound, clock, reset, fifo_stat.count > FIFO_CW'(FIFO_DEPTH))
   // back end only takes entries that are there
   `SSS_ASSERT_IMPLY(a_pop_nonempty, clock, reset, fifo_pop, !fifo_stat.empty)

endmodule

`default_nettype wire

// ===== verif/sql_script_statement_splitter_checker.sv =====
`timescale 1ns / 1ps
// checker for the sql script statement splitter: rebuilds the statement stream
// from accepted req_ and csr_ transactions and compares it with every rsp_ transaction
// depends on sss_pkg only
module sql_script_statement_splitter_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic       req_full,
   input  wire logic [7:0] req_script_byte,
   input  wire logic       req_end_of_script,
   input  wire logic       rsp_empty,
   input  wire logic       rsp_pop,
   input  wire logic [1:0] rsp_kind,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_last_of_run,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [1:0] csr_dialect,
   output int              fail_count,
   output int              pending_count
);
   import sss_pkg::*;

   localparam logic [7:0]  CH_CR     = 8'h0d;
   localparam logic [7:0]  CH_LF     = 8'h0a;
   localparam logic [7:0]  CH_QUOTE  = 8'h27;
   localparam logic [7:0]  CH_DOLLAR = 8'h24;
   localparam logic [7:0]  CH_SEMI   = 8'h3b;
   localparam logic [7:0]  CH_OPEN   = 8'h28;
   localparam logic [7:0]  CH_CLOSE  = 8'h29;
   localparam logic [7:0]  CH_UNDER  = 8'h5f;
   localparam logic [39:0] WORD_BEGIN = "BEGIN";
   localparam logic [23:0] WORD_END   = "END";
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } piece_type;

   piece_type         expected_pieces[$];
   piece_type         step_pieces[$];
   int                failures = 0;
   logic [1:0]        dialect;
   logic signed [7:0] nest_depth;
   logic              dollar_block;
   logic              in_quote;
   logic              dollar_seen;
   logic              in_word;
   logic [2:0]        word_len;
   logic              word_begin_ok;
   logic              word_end_ok;
   logic              stmt_open;

   function automatic logic is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_word_char(logic [7:0] b);
      return is_alpha(b) || (b >= "0" && b <= "9") || b == CH_UNDER;
   endfunction

   task automatic add_piece(kind_type k, logic [7:0] d);
      piece_type p;
      if (step_pieces.size() < 2) begin
         p.kind = k;
         p.data = d;
         p.last = 1'b0;
         step_pieces.push_back(p);
      end
   endtask

   // leading line breaks of a statement are swallowed
   task automatic emit(logic [7:0] b);
      if (!stmt_open && (b == CH_CR || b == CH_LF))
         return;
      stmt_open = 1'b1;
      add_piece(KIND_BYTE, b);
   endtask

   task automatic shift_depth(int d);
      int sum;
      sum = int'(nest_depth) + d;
      if (sum > 127)
         sum = 127;
      if (sum < -128)
         sum = -128;
      nest_depth = 8'(sum);
   endtask

   task automatic word_push(logic [7:0] b);
      logic [7:0] up;
      int         pos;
      int         bi;
      int         ei;
      up  = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      pos = word_len;
      bi  = (pos < 5) ? 4 - pos : 0;
      ei  = (pos < 3) ? 2 - pos : 0;
      word_begin_ok = word_begin_ok && pos < 5 && up == WORD_BEGIN[8*bi +: 8];
      word_end_ok   = word_end_ok && pos < 3 && up == WORD_END[8*ei +: 8];
      if (word_len < 6)
         word_len = word_len + 3'd1;
   endtask

   task automatic word_close();
      if (in_word && !dollar_block) begin
         if (word_begin_ok && word_len == 5)
            shift_depth(1);
         if (word_end_ok && word_len == 3)
            shift_depth(-1);
      end
      in_word       = 1'b0;
      word_len      = '0;
      word_begin_ok = 1'b0;
      word_end_ok   = 1'b0;
   endtask

   task automatic clear_parse();
      nest_depth    = '0;
      dollar_block  = 1'b0;
      in_quote      = 1'b0;
      dollar_seen   = 1'b0;
      in_word       = 1'b0;
      word_len      = '0;
      word_begin_ok = 1'b0;
      word_end_ok   = 1'b0;
      stmt_open     = 1'b0;
   endtask

   task automatic take_byte(logic [7:0] b);
      if (in_quote) begin
         emit(b);
         if (b == CH_QUOTE)
            in_quote = 1'b0;
         return;
      end
      if (dollar_seen) begin
         dollar_seen = 1'b0;
         if (b == CH_DOLLAR) begin
            emit(b);
            dollar_block = !dollar_block;
            return;
         end
      end
      if (in_word) begin
         if (is_word_char(b)) begin
            word_push(b);
            emit(b);
            return;
         end
         word_close();
      end
      if (is_alpha(b) || b == CH_UNDER) begin
         in_word       = 1'b1;
         word_len      = '0;
         word_begin_ok = 1'b1;
         word_end_ok   = 1'b1;
         word_push(b);
         emit(b);
      end else if (b == CH_QUOTE) begin
         emit(b);
         in_quote = 1'b1;
      end else if (dialect == DIALECT_PG && b == CH_DOLLAR) begin
         emit(b);
         dollar_seen = 1'b1;
      end else if (b == CH_SEMI && nest_depth == 0 && !dollar_block) begin
         add_piece(KIND_STMT_END, 8'd0);
         stmt_open = 1'b0;
      end else begin
         if (!dollar_block) begin
            if (b == CH_OPEN)
               shift_depth(1);
            if (b == CH_CLOSE)
               shift_depth(-1);
         end
         if (b != CH_CR) begin
            if (dialect == DIALECT_ORACLE && b == CH_LF)
               emit(CH_CR);
            emit(b);
         end
      end
   endtask

   task automatic split_item(logic [7:0] b, logic eos);
      step_pieces.delete();
      if (eos) begin
         word_close();
         add_piece(in_quote ? KIND_DONE_QUOTE : KIND_DONE_OK, 8'd0);
         clear_parse();
      end else begin
         take_byte(b);
      end
      if (step_pieces.size() > 0)
         step_pieces[step_pieces.size() - 1].last = 1'b1;
      foreach (step_pieces[i])
         expected_pieces.push_back(step_pieces[i]);
   endtask

   always @(posedge clock) begin : watch
      piece_type want;
      if (reset) begin
         dialect = '0;
         clear_parse();
         expected_pieces.delete();
      end else begin
         if (req_push && !req_full)
            split_item(req_script_byte, req_end_of_script);
         if (csr_valid && csr_ready)
            dialect = csr_dialect;
         if (rsp_pop && !rsp_empty) begin
            if (expected_pieces.size() == 0) begin
               failures = failures + 1;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected transaction: kind %0d byte %02h last %0b",
                           rsp_kind, rsp_out_byte, rsp_last_of_run);
            end else begin
               want = expected_pieces.pop_front();
               if (rsp_kind !== want.kind || rsp_out_byte !== want.data ||
                   rsp_last_of_run !== want.last) begin
                  failures = failures + 1;
                  if (failures <= REPORT_LIMIT)
                     $display("mismatch: kind %0d/%0d byte %02h/%02h last %0b/%0b (exp/act)",
                              want.kind, rsp_kind, want.data, rsp_out_byte,
                              want.last, rsp_last_of_run);
               end
            end
         end
      end
      pending_count <= expected_pieces.size();
      fail_count    <= failures;
   end

endmodule

// ===== verif/sql_script_statement_splitter_test.sv =====
`timescale 1ns / 1ps
// testbench top for the sql script statement splitter: drives scripts, dialect
// writes and consumer stalls, and gives the verdict from the checker's failure count
// depends on sss_pkg, sql_script_statement_splitter and its checker module
module sql_script_statement_splitter_test;
   import sss_pkg::*;

   localparam logic [1:0] DIALECT_GENERIC = 2'd0;
   localparam logic [1:0] DIALECT_SPARE   = 2'd3;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam int NEST_PAREN    = 0;
   localparam int NEST_BLOCK    = 1;
   localparam int HOLD_CYCLES   = 120;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 500;
   localparam int PHASES        = 7;
   localparam logic [1:0] PHASE_DIALECTS [PHASES] = '{DIALECT_SPARE, DIALECT_PG,
      DIALECT_ORACLE, DIALECT_GENERIC, DIALECT_PG, DIALECT_ORACLE, DIALECT_SPARE};

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_script_byte;
   logic       req_end_of_script;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_dialect;
   int         fail_count;
   int         pending_count;

   logic [7:0] script_q[$];
   logic [1:0] cur_dialect = DIALECT_GENERIC;
   int         items_sent = 0;
   int         burst_left = 0;
   int         hold_asks = 0;
   int         holds_served = 0;
   string      word_pool[12] = '{"select", "begin", "end", "beginx", "ends", "_t1",
                                  "beg", "en", "x9", "BEGIN_", "from", "e"};
   logic [7:0] quote_specials[4] = '{CH_CR, CH_LF, CH_SEMI, CH_OPEN};

   sql_script_statement_splitter u_top (.*);

   sql_script_statement_splitter_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic push_item(logic [7:0] b, logic eos);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      end
      burst_left--;
      req_push          <= 1'b1;
      req_script_byte   <= b;
      req_end_of_script <= eos;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic finish_script();
      foreach (script_q[i])
         push_item(script_q[i], 1'b0);
      script_q.delete();
      push_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text();
      foreach (script_q[i])
         push_item(script_q[i], 1'b0);
      script_q.delete();
   endtask

   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dialect(logic [1:0] d);
      settle();
      csr_valid   <= 1'b1;
      csr_dialect <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cur_dialect = d;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         script_q.push_back(s[i]);
   endtask

   // random letter case, usually followed by a space
   task automatic add_word(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1))
            c = c ^ 8'h20;
         script_q.push_back(c);
      end
      if ($urandom_range(0, 3) != 0)
         add_text(" ");
   endtask

   task automatic add_quote(logic closed);
      logic [7:0] c;
      int         n;
      script_q.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         c = ($urandom_range(0, 2) == 0) ? quote_specials[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
         if (c == CH_QUOTE)
            c = CH_SEMI;
         script_q.push_back(c);
      end
      if (closed)
         script_q.push_back(CH_QUOTE);
   endtask

   task automatic add_statement();
      int open_kinds[$];
      int tokens;
      int n;
      if ($urandom_range(0, 3) == 0)
         script_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         case ($urandom_range(0, 11))
            0, 1: add_word(word_pool[$urandom_range(0, 11)]);
            2: begin
               add_text("(");
               open_kinds.push_back(NEST_PAREN);
            end
            3: begin
               if (open_kinds.size() > 0 && open_kinds[$] == NEST_PAREN) begin
                  void'(open_kinds.pop_back());
                  add_text(")");
               end else begin
                  add_text(" ");
               end
            end
            4: begin
               add_word(" begin");
               open_kinds.push_back(NEST_BLOCK);
            end
            5: begin
               if (open_kinds.size() > 0 && open_kinds[$] == NEST_BLOCK) begin
                  void'(open_kinds.pop_back());
                  add_word(" end");
               end else begin
                  add_word("x");
               end
            end
            6: add_quote(1'b1);
            7: begin
               case ($urandom_range(0, 3))
                  0: script_q.push_back(CH_CR);
                  1: script_q.push_back(CH_LF);
                  2: script_q.push_back(CH_TAB);
                  default: begin
                     script_q.push_back(CH_CR);
                     script_q.push_back(CH_LF);
                  end
               endcase
            end
            8: begin
               if (cur_dialect == DIALECT_PG) begin
                  add_text("$$");
                  n = $urandom_range(0, 4);
                  repeat (n) begin
                     case ($urandom_range(0, 4))
                        0: add_text(";");
                        1: add_text("(");
                        2: add_word(" end");
                        3: add_text(")");
                        default: add_word("begin");
                     endcase
                  end
                  add_text("$$");
               end else begin
                  add_text("$");
               end
            end
            9: add_text((cur_dialect == DIALECT_PG) ? "$1" : ",");
            10: add_text(($urandom_range(0, 1)) ? " = 42" : "*");
            default: begin
               if ($urandom_range(0, 7) == 0)
                  script_q.push_back(8'($urandom_range(0, 255)));
               else
                  add_text(" ");
            end
         endcase
      end
      while (open_kinds.size() > 0) begin
         if (open_kinds.pop_back() == NEST_PAREN)
            add_text(")");
         else
            add_word(" end");
      end
      add_text(";");
   endtask

   task automatic add_script();
      int n;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(5, 15);
         repeat (n) script_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) add_statement();
         if ($urandom_range(0, 4) == 0)
            add_word("tail x");
         if ($urandom_range(0, 15) == 0)
            add_quote(1'b0);
      end
      finish_script();
   endtask

   // nesting driven into both saturation limits and back to zero
   task automatic add_depth_extremes();
      add_text("x");
      repeat (129) add_text("(");
      repeat (127) add_text(")");
      add_text(";");
      repeat (129) add_text(")");
      repeat (128) add_text("(");
      add_text(";");
      finish_script();
   endtask

   initial begin : consumer
      int stall_mode;
      int mode_left;
      rsp_pop <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_asks) begin
            holds_served = holds_served + 1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(8, 64);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= $urandom_range(0, 1);
            2: rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int base;
      reset             <= 1'b1;
      req_push          <= 1'b0;
      req_script_byte   <= 8'd0;
      req_end_of_script <= 1'b0;
      csr_valid         <= 1'b0;
      csr_dialect       <= DIALECT_GENERIC;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // leading newline, mixed-case begin/end split by a high byte
      script_q.push_back(CH_LF);
      add_text("Begin");
      script_q.push_back(8'hff);
      add_text("eND;");
      send_text();
      // quote keeps cr and semicolon, trailing statement closed by the script end without a statement-end marker
      script_q.push_back(CH_QUOTE);
      script_q.push_back(CH_CR);
      add_text(";'");
      finish_script();
      // unterminated quote
      script_q.push_back(CH_QUOTE);
      finish_script();
      write_dialect(DIALECT_PG);
      add_text("$$;$$;");
      send_text();
      write_dialect(DIALECT_ORACLE);
      add_text("a");
      script_q.push_back(CH_LF);
      add_text(";");
      send_text();

      base = items_sent;
      for (int p = 0; p < PHASES; p++) begin
         write_dialect(PHASE_DIALECTS[p]);
         if (p == 2 || p == 5)
            hold_asks <= hold_asks + 1;
         if (p == 3)
            add_depth_extremes();
         while (items_sent < base + RANDOM_ITEMS * (p + 1) / PHASES)
            add_script();
      end

      settle();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
